// ----- design/circular_queue_with_listing_assert.svh -----
// assertion macros used by the circular queue back end
`ifndef CIRCULAR_QUEUE_WITH_LISTING_ASSERT_SVH
`define CIRCULAR_QUEUE_WITH_LISTING_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define CQWL_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// same-cycle implication checked at every clock edge out of reset
`define CQWL_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/cqwl_pkg.sv -----
// shared types and constants of the circular queue with listing
package cqwl_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int KIND_W        = 3;
   localparam int DATA_W        = 32;
   localparam int STATUS_W      = 2;
   localparam int OCC_W         = 5;

   // command kinds as they arrive on the request channel
   localparam logic [KIND_W-1:0] KIND_INSERT      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK_FIRST  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PEEK_LAST   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LIST_NONNEG = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LIST_REV    = 3'd5;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd3;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_REMOVE,
      OP_PEEK_FIRST,
      OP_PEEK_LAST,
      OP_LIST_NONNEG,
      OP_LIST_REV
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  value;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

endpackage

// ----- design/cqwl_req_if.sv -----
// request channel interface: command kind and data word
interface cqwl_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [cqwl_pkg::KIND_W-1:0]   kind;
   logic signed [cqwl_pkg::DATA_W-1:0]   value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

// ----- design/cqwl_rsp_if.sv -----
// response channel interface: status, data, occupancy and last marker
interface cqwl_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic        [cqwl_pkg::STATUS_W-1:0] status;
   logic signed [cqwl_pkg::DATA_W-1:0]   data;
   logic        [cqwl_pkg::OCC_W-1:0]    occupancy;
   logic                                 last;

   modport source (output valid, output status, output data, output occupancy, output last,
                   input ready);
   modport sink   (input valid, input status, input data, input occupancy, input last,
                   output ready);
endinterface

// ----- design/circular_queue_with_listing.sv -----
// an insert, or a command that finds the queue full or empty, is answered in the response
// register; remove, peek and listing read the memory first, then read one entry a cycle
// while the response channel is not stalled; throughput: insert one command a cycle while
// it is not stalled; remove, peek and listing hold off the next command until the walk ends
// reset: head 0, tail DEPTH-1, count 0, command queue and response register empty;
// entry storage is not cleared and needs no clearing pass
module circular_queue_with_listing #(
   parameter int DEPTH = cqwl_pkg::DEFAULT_DEPTH
) (
   input logic        clock,
   input logic        reset,
   cqwl_req_if.sink   req_ch,
   cqwl_rsp_if.source rsp_ch
);
   import cqwl_pkg::*;

   // decoded commands between front end and command queue
   logic    push_valid, push_ready;
   cmd_type push_cmd;

   // command queue to back end
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   // front end: takes each request transfer, drops unused kinds
   cqwl_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   // short queue so a long listing does not block request transfers at once
   cqwl_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   // back end: storage, pointers, walks and the response register
   cqwl_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd       (pop_cmd),
      .cmd_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- design/cqwl_front.sv -----
// front end: accepts requests, decodes the kind and drops unused codes
module cqwl_front (
   cqwl_req_if.sink          req_ch,
   output logic              push_valid,
   output cqwl_pkg::cmd_type push_cmd,
   input  logic              push_ready
);
   import cqwl_pkg::*;

   logic known;

   always_comb begin
      known       = 1'b1;
      push_cmd.op = OP_INSERT;
      unique case (req_ch.kind)
         KIND_INSERT:      push_cmd.op = OP_INSERT;
         KIND_REMOVE:      push_cmd.op = OP_REMOVE;
         KIND_PEEK_FIRST:  push_cmd.op = OP_PEEK_FIRST;
         KIND_PEEK_LAST:   push_cmd.op = OP_PEEK_LAST;
         KIND_LIST_NONNEG: push_cmd.op = OP_LIST_NONNEG;
         KIND_LIST_REV:    push_cmd.op = OP_LIST_REV;
         default:          known = 1'b0;
      endcase
      push_cmd.value = req_ch.value;
   end

   // unused kinds are taken and dropped
   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid && known;

endmodule

// ----- design/cqwl_cmd_fifo.sv -----
// two-entry command queue between front end and back end
module cqwl_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  cqwl_pkg::cmd_type push_cmd,
   output logic              push_ready,
   output logic              pop_valid,
   output cqwl_pkg::cmd_type pop_cmd,
   input  logic              pop_ready
);
   import cqwl_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- design/cqwl_back.sv -----
// back end: queue storage, pointers, listing walk and response register
`include "circular_queue_with_listing_assert.svh"

module cqwl_back #(
   parameter int DEPTH = cqwl_pkg::DEFAULT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cqwl_pkg::cmd_type cmd,
   output logic              cmd_ready,
   cqwl_rsp_if.source        rsp_ch
);
   import cqwl_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? LAST_IDX : idx - 1'b1;
   endfunction

   logic signed [DATA_W-1:0] mem [DEPTH];

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         ptr_ff, ptr_in;
   logic [CNT_W-1:0]         left_ff, left_in;
   logic                     dir_rev_ff, dir_rev_in;
   logic                     filter_ff, filter_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic                     rd_last_ff, rd_last_in;
   logic signed [DATA_W-1:0] rd_data_ff;
   logic                     pend_valid_ff, pend_valid_in;
   logic signed [DATA_W-1:0] pend_data_ff, pend_data_in;

   logic                     rsp_valid_ff;
   logic [STATUS_W-1:0]      status_ff;
   logic signed [DATA_W-1:0] data_ff;
   logic [OCC_W-1:0]         occ_ff;
   logic                     last_ff;

   logic                     slot_free, cmd_pop, start_walk, consume, neg;
   logic                     rd_en, wr_en;
   logic                     emit, emit_last;
   logic [STATUS_W-1:0]      emit_status;
   logic signed [DATA_W-1:0] emit_data;

   assign slot_free  = !rsp_valid_ff || rsp_ch.ready;
   assign cmd_ready  = (state_ff == ST_IDLE) && slot_free;
   assign cmd_pop    = cmd_valid && cmd_ready;
   assign start_walk = cmd_pop && (cmd.op != OP_INSERT) && (count_ff != '0);
   assign neg        = rd_data_ff[DATA_W-1];
   assign consume    = (state_ff == ST_WALK) && rd_valid_ff &&
                       (filter_ff ? (neg || !pend_valid_ff || slot_free) : slot_free);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start_walk) state_in = ST_WALK;
         ST_WALK:   if (consume && rd_last_ff) state_in = filter_ff ? ST_FINISH : ST_IDLE;
         ST_FINISH: if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      left_in       = left_ff;
      dir_rev_in    = dir_rev_ff;
      filter_in     = filter_ff;
      rd_valid_in   = rd_valid_ff;
      rd_last_in    = rd_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      emit          = 1'b0;
      emit_status   = STATUS_OK;
      emit_data     = '0;
      emit_last     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               if (cmd.op == OP_INSERT) begin
                  emit = 1'b1;
                  if (count_ff == FULL_CNT) begin
                     emit_status = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     tail_in  = idx_inc(tail_ff);
                     count_in = count_ff + 1'b1;
                  end
               end else if (count_ff == '0) begin
                  emit        = 1'b1;
                  emit_status = STATUS_EMPTY;
               end else begin
                  // single reads run as a walk of one entry
                  left_in       = (cmd.op == OP_LIST_NONNEG || cmd.op == OP_LIST_REV) ?
                                  count_ff : ONE_CNT;
                  filter_in     = (cmd.op == OP_LIST_NONNEG);
                  dir_rev_in    = (cmd.op == OP_LIST_REV);
                  ptr_in        = (cmd.op == OP_PEEK_LAST || cmd.op == OP_LIST_REV) ?
                                  tail_ff : head_ff;
                  rd_valid_in   = 1'b0;
                  pend_valid_in = 1'b0;
                  if (cmd.op == OP_REMOVE) begin
                     head_in  = idx_inc(head_ff);
                     count_in = count_ff - 1'b1;
                  end
               end
            end
         end
         ST_WALK: begin
            if (consume) begin
               rd_valid_in = 1'b0;
               if (filter_ff) begin
                  // hold one match back so the final one can carry last
                  if (!neg) begin
                     emit          = pend_valid_ff;
                     emit_data     = pend_data_ff;
                     emit_last     = 1'b0;
                     pend_valid_in = 1'b1;
                     pend_data_in  = rd_data_ff;
                  end
               end else begin
                  emit      = 1'b1;
                  emit_data = rd_data_ff;
                  emit_last = rd_last_ff;
               end
            end
            if ((left_ff != '0) && (!rd_valid_ff || consume)) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               rd_last_in  = (left_ff == ONE_CNT);
               left_in     = left_ff - 1'b1;
               ptr_in      = dir_rev_ff ? idx_dec(ptr_ff) : idx_inc(ptr_ff);
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               emit        = 1'b1;
               emit_status = pend_valid_ff ? STATUS_OK : STATUS_NONE;
               emit_data   = pend_valid_ff ? pend_data_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= LAST_IDX;
         count_ff      <= '0;
         left_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         left_ff       <= left_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      dir_rev_ff   <= dir_rev_in;
      filter_ff    <= filter_in;
      rd_last_ff   <= rd_last_in;
      pend_data_ff <= pend_data_in;
      if (emit) begin
         status_ff <= emit_status;
         data_ff   <= emit_data;
         occ_ff    <= OCC_W'(count_in);
         last_ff   <= emit_last;
      end
   end

   // storage: one write port at the new tail, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_inc(tail_ff)] <= cmd.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[ptr_ff];
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.data      = data_ff;
   assign rsp_ch.occupancy = occ_ff;
   assign rsp_ch.last      = last_ff;

   `CQWL_ASSERT_ALWAYS(a_count_bound, count_ff <= FULL_CNT, "count above depth")
   `CQWL_ASSERT_IMPLY(a_read_in_walk, rd_valid_ff, state_ff == ST_WALK, "read data outside walk")
   `CQWL_ASSERT_IMPLY(a_pend_filter, pend_valid_ff, filter_ff, "held match outside filter walk")
   `CQWL_ASSERT_IMPLY(a_emit_room, emit, slot_free, "response overwritten while stalled")

endmodule
